// ----- sv/two_channel_iq_phasor_ratio_core_defines.svh -----
// Assertion macros shared by the checker.
`ifndef TWO_CHANNEL_IQ_PHASOR_RATIO_CORE_DEFINES_SVH
`define TWO_CHANNEL_IQ_PHASOR_RATIO_CORE_DEFINES_SVH

`define TCIPR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define TCIPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tcipr_pkg.sv -----
package tcipr_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TABLE_BITS_DEF  = 10;
    localparam int SUM_BITS        = 41;
    localparam int MAG_BITS        = 44;
    localparam int ANGLE_BITS      = 24;
    localparam int CORDIC_STEPS    = 22;
    localparam longint HALF_TURN    = 64'sd8388608;
    localparam longint QUARTER_TURN = 64'sd4194304;
    localparam longint ROT_START    = 64'sd326006488;

    localparam logic REG_PHASE_INC = 1'b0;
    localparam logic REG_WRAP_MODE = 1'b1;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sig_i;
        logic signed [SUM_BITS-1:0] sig_q;
        logic signed [SUM_BITS-1:0] ref_i;
        logic signed [SUM_BITS-1:0] ref_q;
    } tcipr_sums_t;

    function automatic logic [ANGLE_BITS-1:0] atan_turn(input logic [4:0] i);
        logic [ANGLE_BITS-1:0] a;
        case (i)
            5'd0:    a = 24'd2097152;
            5'd1:    a = 24'd1238021;
            5'd2:    a = 24'd654136;
            5'd3:    a = 24'd332050;
            5'd4:    a = 24'd166669;
            5'd5:    a = 24'd83416;
            5'd6:    a = 24'd41718;
            5'd7:    a = 24'd20860;
            5'd8:    a = 24'd10430;
            5'd9:    a = 24'd5215;
            5'd10:   a = 24'd2608;
            5'd11:   a = 24'd1304;
            5'd12:   a = 24'd652;
            5'd13:   a = 24'd326;
            5'd14:   a = 24'd163;
            5'd15:   a = 24'd81;
            5'd16:   a = 24'd41;
            5'd17:   a = 24'd20;
            5'd18:   a = 24'd10;
            5'd19:   a = 24'd5;
            5'd20:   a = 24'd3;
            5'd21:   a = 24'd1;
            default: a = 24'd0;
        endcase
        return a;
    endfunction

    function automatic longint round_clamp(input longint v);
        longint r;
        r = (v + 64'sd8192) >>> 14;
        if (r > 64'sd32767) r = 64'sd32767;
        if (r < -64'sd32767) r = -64'sd32767;
        return r;
    endfunction

    // Table entry: cosine in the upper half, sine in the lower half.
    function automatic logic [31:0] sincos_entry(input int idx, input int tb);
        longint a;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint c;
        longint s;
        logic   flip;
        a = (longint'(idx) << (24 - tb)) & 64'sd16777215;
        z = (a >= HALF_TURN) ? a - 64'sd16777216 : a;
        flip = 1'b0;
        x = ROT_START;
        y = 0;
        if (z > QUARTER_TURN) begin
            z = z - HALF_TURN;
            flip = 1'b1;
        end else if (z < -QUARTER_TURN) begin
            z = z + HALF_TURN;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_turn(5'(i)));
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_turn(5'(i)));
            end
        end
        c = round_clamp(x);
        s = round_clamp(y);
        if (flip) begin
            c = -c;
            s = -s;
        end
        return {c[15:0], s[15:0]};
    endfunction

endpackage

// ----- sv/tcipr_front.sv -----
module tcipr_front import tcipr_pkg::*; #(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_signal_sample,
    input  logic [SAMPLE_BITS-1:0] s_reference_sample,
    input  logic                   s_record_end,
    input  logic [31:0]            phase_increment,
    output logic                   push_valid,
    input  logic                   push_ready,
    output tcipr_sums_t            push_sums
);

    localparam int TABLE_DEPTH = 2 ** SINE_TABLE_BITS;
    localparam int PROD_BITS   = SAMPLE_BITS + 17;

    logic [31:0] rom [TABLE_DEPTH];

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
        assign rom[k] = sincos_entry(k, SINE_TABLE_BITS);
    end

    logic                        en;
    logic [31:0]                 acc_reg;
    logic                        v1_reg;
    logic                        end1_reg;
    logic [31:0]                 trig_reg;
    logic [SAMPLE_BITS-1:0]      sig1_reg;
    logic [SAMPLE_BITS-1:0]      ref1_reg;
    logic                        v2_reg;
    logic                        end2_reg;
    logic signed [PROD_BITS-1:0] p_si_reg;
    logic signed [PROD_BITS-1:0] p_sq_reg;
    logic signed [PROD_BITS-1:0] p_ri_reg;
    logic signed [PROD_BITS-1:0] p_rq_reg;
    tcipr_sums_t                 sums_reg;
    tcipr_sums_t                 sums_next;
    logic signed [15:0]          cos_w;
    logic signed [15:0]          sin_w;
    logic signed [SAMPLE_BITS:0] sig_w;
    logic signed [SAMPLE_BITS:0] ref_w;

    assign en         = !(v2_reg && end2_reg && !push_ready);
    assign s_ready    = en;
    assign push_valid = v2_reg && end2_reg;
    assign push_sums  = sums_next;

    assign cos_w = trig_reg[31:16];
    assign sin_w = trig_reg[15:0];
    assign sig_w = $signed({1'b0, sig1_reg});
    assign ref_w = $signed({1'b0, ref1_reg});

    always_comb begin
        sums_next.sig_i = sums_reg.sig_i + SUM_BITS'(p_si_reg);
        sums_next.sig_q = sums_reg.sig_q + SUM_BITS'(p_sq_reg);
        sums_next.ref_i = sums_reg.ref_i + SUM_BITS'(p_ri_reg);
        sums_next.ref_q = sums_reg.ref_q + SUM_BITS'(p_rq_reg);
    end

    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            trig_reg <= rom[acc_reg[31 -: SINE_TABLE_BITS]];
            sig1_reg <= s_signal_sample;
            ref1_reg <= s_reference_sample;
            end1_reg <= s_record_end;
        end
        if (en) begin
            p_si_reg <= sig_w * cos_w;
            p_sq_reg <= sig_w * sin_w;
            p_ri_reg <= ref_w * cos_w;
            p_rq_reg <= ref_w * sin_w;
            end2_reg <= end1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            sums_reg <= '0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            if (s_valid) begin
                acc_reg <= s_record_end ? '0 : acc_reg + phase_increment;
            end
            if (v2_reg) begin
                sums_reg <= end2_reg ? '0 : sums_next;
            end
        end
    end

endmodule

// ----- sv/tcipr_queue.sv -----
module tcipr_queue import tcipr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  tcipr_sums_t push_sums,
    output logic        pop_valid,
    input  logic        pop_ready,
    output tcipr_sums_t pop_sums
);

    tcipr_sums_t entry_reg [2];
    logic [1:0]  count_reg;
    logic        wr_reg;
    logic        rd_reg;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_sums   = entry_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_reg] <= push_sums;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end else begin
            if (do_push) wr_reg <= !wr_reg;
            if (do_pop) rd_reg <= !rd_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ----- sv/tcipr_back.sv -----
module tcipr_back import tcipr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  tcipr_sums_t        pop_sums,
    input  logic               wrap_mode,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_gain_ratio,
    output logic signed [16:0] m_phase_difference,
    output logic               m_reference_zero
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ROT  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                       state_reg;
    logic [4:0]                   step_reg;
    logic signed [MAG_BITS-1:0]   xs_reg, ys_reg, xr_reg, yr_reg;
    logic [ANGLE_BITS-1:0]        zs_reg, zr_reg;
    logic                         zs0_reg, zr0_reg;
    logic [MAG_BITS-1:0]          rem_reg;
    logic [MAG_BITS-1:0]          div_reg;
    logic [31:0]                  dq_reg;
    logic                         sat_reg;
    logic                         rzero_reg;
    logic [31:0]                  ratio_reg;
    logic signed [16:0]           phase_reg;

    logic signed [MAG_BITS-1:0]   in_sx, in_sy, in_rx, in_ry;
    logic [ANGLE_BITS-1:0]        at_w;
    logic [MAG_BITS-1:0]          mag_s, mag_r;
    logic signed [ANGLE_BITS:0]   ang_s, ang_r;
    logic signed [ANGLE_BITS+1:0] diff_w;
    logic signed [17:0]           rnd_w;
    logic signed [16:0]           phase_w;
    logic [MAG_BITS:0]            trial_w;
    logic                         ge_w;

    assign in_sx = MAG_BITS'(pop_sums.sig_i);
    assign in_sy = MAG_BITS'(pop_sums.sig_q);
    assign in_rx = MAG_BITS'(pop_sums.ref_i);
    assign in_ry = MAG_BITS'(pop_sums.ref_q);
    assign at_w  = atan_turn(step_reg);

    assign pop_ready          = (state_reg == ST_IDLE);
    assign m_valid            = (state_reg == ST_OUT);
    assign m_gain_ratio       = ratio_reg;
    assign m_phase_difference = phase_reg;
    assign m_reference_zero   = rzero_reg;

    assign mag_s = zs0_reg ? '0 : MAG_BITS'(xs_reg);
    assign mag_r = zr0_reg ? '0 : MAG_BITS'(xr_reg);

    always_comb begin
        if (zs0_reg) ang_s = '0;
        else if (zs_reg > 24'd8388608) ang_s = $signed({1'b0, zs_reg}) - 25'sd16777216;
        else ang_s = $signed({1'b0, zs_reg});
        if (zr0_reg) ang_r = '0;
        else if (zr_reg > 24'd8388608) ang_r = $signed({1'b0, zr_reg}) - 25'sd16777216;
        else ang_r = $signed({1'b0, zr_reg});
        diff_w = (ANGLE_BITS+2)'(ang_s) - (ANGLE_BITS+2)'(ang_r) + 26'sd128;
        rnd_w  = diff_w[ANGLE_BITS+1:8];
        if (wrap_mode) phase_w = $signed({1'b0, rnd_w[15:0]});
        else if (rnd_w > 18'sd65535) phase_w = 17'sd65535;
        else if (rnd_w < -18'sd65535) phase_w = -17'sd65535;
        else phase_w = rnd_w[16:0];
    end

    assign trial_w = {rem_reg, dq_reg[31]};
    assign ge_w    = (trial_w >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                step_reg <= '0;
                zs0_reg  <= (in_sx == '0) && (in_sy == '0);
                zr0_reg  <= (in_rx == '0) && (in_ry == '0);
                xs_reg   <= in_sx[MAG_BITS-1] ? -in_sx : in_sx;
                ys_reg   <= in_sx[MAG_BITS-1] ? -in_sy : in_sy;
                zs_reg   <= in_sx[MAG_BITS-1] ? 24'd8388608 : 24'd0;
                xr_reg   <= in_rx[MAG_BITS-1] ? -in_rx : in_rx;
                yr_reg   <= in_rx[MAG_BITS-1] ? -in_ry : in_ry;
                zr_reg   <= in_rx[MAG_BITS-1] ? 24'd8388608 : 24'd0;
            end
            ST_ROT: begin
                step_reg <= step_reg + 5'd1;
                if (ys_reg > 0) begin
                    xs_reg <= xs_reg + (ys_reg >>> step_reg);
                    ys_reg <= ys_reg - (xs_reg >>> step_reg);
                    zs_reg <= zs_reg + at_w;
                end else begin
                    xs_reg <= xs_reg - (ys_reg >>> step_reg);
                    ys_reg <= ys_reg + (xs_reg >>> step_reg);
                    zs_reg <= zs_reg - at_w;
                end
                if (yr_reg > 0) begin
                    xr_reg <= xr_reg + (yr_reg >>> step_reg);
                    yr_reg <= yr_reg - (xr_reg >>> step_reg);
                    zr_reg <= zr_reg + at_w;
                end else begin
                    xr_reg <= xr_reg - (yr_reg >>> step_reg);
                    yr_reg <= yr_reg + (xr_reg >>> step_reg);
                    zr_reg <= zr_reg - at_w;
                end
            end
            ST_PREP: begin
                step_reg  <= '0;
                rem_reg   <= mag_s >> 16;
                dq_reg    <= {mag_s[15:0], 16'b0};
                div_reg   <= mag_r;
                rzero_reg <= (mag_r == '0);
                sat_reg   <= ({16'b0, mag_s} >= {mag_r, 16'b0});
                phase_reg <= phase_w;
            end
            ST_DIV: begin
                step_reg <= step_reg + 5'd1;
                rem_reg  <= ge_w ? MAG_BITS'(trial_w - {1'b0, div_reg}) : MAG_BITS'(trial_w);
                dq_reg   <= {dq_reg[30:0], ge_w};
                if (step_reg == 5'd31) begin
                    ratio_reg <= (rzero_reg || sat_reg) ? 32'hFFFFFFFF : {dq_reg[30:0], ge_w};
                end
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: if (pop_valid) state_reg <= ST_ROT;
                ST_ROT:  if (step_reg == 5'(CORDIC_STEPS - 1)) state_reg <= ST_PREP;
                ST_PREP: state_reg <= ST_DIV;
                ST_DIV:  if (step_reg == 5'd31) state_reg <= ST_OUT;
                ST_OUT:  if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/two_channel_iq_phasor_ratio_core.sv -----
// Two-channel single-bin IQ demodulator. It takes one sample pair per clock, unless stalled,
// through a two-stage table and multiply pipeline into four running sums. The pair marked as
// record end closes the record and hands its sums to a two-entry queue. In the back end each
// record then passes through 22 shared CORDIC vectoring steps for both channels, a setup
// state, and 32 steps of a radix-2 divider before the result transfer. Sample transfers stall
// only when two finished records already wait in the queue and a third ends.
module two_channel_iq_phasor_ratio_core import tcipr_pkg::*; #(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_signal_sample,
    input  logic [SAMPLE_BITS-1:0] s_reference_sample,
    input  logic                   s_record_end,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_gain_ratio,
    output logic signed [16:0]     m_phase_difference,
    output logic                   m_reference_zero
);

    logic [31:0] phase_inc_reg;
    logic        wrap_reg;
    logic        push_valid, push_ready, pop_valid, pop_ready;
    tcipr_sums_t push_sums, pop_sums;

    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_PHASE_INC: prdata = phase_inc_reg;
            REG_WRAP_MODE: prdata = {31'b0, wrap_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= '0;
            wrap_reg      <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_PHASE_INC: phase_inc_reg <= pwdata;
                REG_WRAP_MODE: wrap_reg <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    tcipr_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_signal_sample(s_signal_sample),
        .s_reference_sample(s_reference_sample),
        .s_record_end(s_record_end),
        .phase_increment(phase_inc_reg),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_sums(push_sums)
    );

    tcipr_queue u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_sums(push_sums),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_sums(pop_sums)
    );

    tcipr_back u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_sums(pop_sums),
        .wrap_mode(wrap_reg),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_gain_ratio(m_gain_ratio),
        .m_phase_difference(m_phase_difference),
        .m_reference_zero(m_reference_zero)
    );

endmodule

// ----- sv/tcipr_checker.sv -----
`include "two_channel_iq_phasor_ratio_core_defines.svh"

module tcipr_checker import tcipr_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [31:0]        m_gain_ratio,
    input logic signed [16:0] m_phase_difference,
    input logic               m_reference_zero
);

    `TCIPR_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_gain_ratio), "result dropped before transfer")
    `TCIPR_ASSERT_SAME(a_zero_sat, m_valid && m_reference_zero, m_gain_ratio == 32'hFFFFFFFF, "zero reference without saturated ratio")
    `TCIPR_ASSERT_SAME(a_phase_range, m_valid, m_phase_difference != -17'sd65536, "phase difference out of range")

endmodule

bind two_channel_iq_phasor_ratio_core tcipr_checker u_checker (.*);
